// ===== rtl/mcgd_pkg.sv =====
// Shared types and constants for the memcomparable group decoder.
// No dependencies; imported by every module of the block but the queue.
package mcgd_pkg;

	localparam int GROUP_BYTES_DEF = 8;
	localparam int MAX_GROUPS_DEF  = 256;
	localparam int QUEUE_DEPTH     = 4;

	localparam int TOP_MARK     = 255;
	localparam int CONS_W       = 12;
	localparam int CONS_MAX     = 4095;
	// result count per queued entry; covers group sizes up to 31
	localparam int CNT_W        = 5;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 24;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_TRUNC = 2'd1,
		ERR_PAD   = 2'd2,
		ERR_MARK  = 2'd3
	} err_t;

	// control part of one queued entry: how to turn it into result words
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic              has;
		logic              done;
		err_t              err;
		logic [CONS_W-1:0] consumed;
	} ctl_t;

	function automatic int cons_limit(input int gb, input int mg);
		int lim;
		begin
			lim = mg * (gb + 1);
			return (lim > CONS_MAX) ? CONS_MAX : lim;
		end
	endfunction

endpackage

// ===== rtl/memcomparable_group_decoder_core.sv =====
// Top level of the memcomparable group decoder: front end, entry queue, back end.
// Depends on mcgd_pkg, mcgd_front, mcgd_fifo, mcgd_back.
//
// Use: encoded key bytes enter on the s_ group, one word per byte, s_tlast set on
// the final readable byte. Groups are GROUP_BYTES payload bytes plus a marker.
// Payload bytes are held in the front end; the marker turns the group into one
// queue entry. The back end emits that entry as up to GROUP_BYTES result words.
// Errors (truncation, nonzero pad, low marker) set done_res on the last word
// of their entry, which is a single word but for a full group that ends the
// input. A byte after a finished key starts a new key. Throughput: one input
// byte per cycle while s_tready is high; one result word per cycle out while
// m_tready is high, so a full group (GROUP_BYTES + 1 bytes in, GROUP_BYTES
// words out) keeps pace. The entry is written into the queue when the marker
// is taken, then loaded from the queue head into the free output register.
// s_tready drops only when the entry queue is full, i.e. when m_tready has been
// held low long enough; a stalled output word holds in its register.
// Reset clears fill and consumed counters, queue pointers and the output valid.
module memcomparable_group_decoder_core #(
	parameter int GROUP_BYTES = mcgd_pkg::GROUP_BYTES_DEF,
	parameter int MAX_GROUPS  = mcgd_pkg::MAX_GROUPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mcgd_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] in_byte
	input  logic                              s_tlast,  // end_of_input
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] out_byte, [8] done_res, [10:9] error, [22:11] consumed, [23] zero
	output logic [mcgd_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tuser,  // has_byte
	output logic                              m_tlast   // last
);
	import mcgd_pkg::*;

	localparam int ENTRY_W = GROUP_BYTES * 8 + $bits(ctl_t);
	localparam int LIMIT   = cons_limit(GROUP_BYTES, MAX_GROUPS);

	logic                        accept, push, pop, q_empty, q_full;
	logic [GROUP_BYTES-1:0][7:0] push_data, head_data;
	ctl_t                        push_ctl, head_ctl;
	logic [ENTRY_W-1:0]          wr_entry, rd_entry;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	mcgd_front #(
		.GROUP_BYTES(GROUP_BYTES),
		.MAX_GROUPS (MAX_GROUPS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (s_tdata[7:0]),
		.end_of_input(s_tlast),
		.push        (push),
		.push_data   (push_data),
		.push_ctl    (push_ctl)
	);

	assign wr_entry = {push_data, push_ctl};
	assign {head_data, head_ctl} = rd_entry;

	mcgd_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_entry),
		.pop    (pop),
		.rd_data(rd_entry),
		.empty  (q_empty),
		.full   (q_full)
	);

	mcgd_back #(
		.GROUP_BYTES(GROUP_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(!q_empty),
		.head_data (head_data),
		.head_ctl  (head_ctl),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// any error word closes the key and is the last word of its entry
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:9] != ERR_NONE) |-> m_tdata[8] && m_tlast)
		else $error("error word without done/last");

	// words without payload are always single, key-closing words
	a_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[8] && (m_tdata[7:0] == 8'd0))
		else $error("empty word is not a closing word");

	// consumed count never passes its saturation bound
	a_cons_lim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[22:11] <= CONS_W'(LIMIT)))
		else $error("consumed count above bound");

	// queue never overflows: a push never lands on a full queue
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full queue");

endmodule

// ===== rtl/mcgd_fifo.sv =====
// Small register queue between the classifier and the emitter.
// Generic width and depth; no package dependency.
module mcgd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mcgd_front.sv =====
// Front end: buffers payload bytes, classifies each marker, counts consumed bytes.
// Depends on mcgd_pkg.
module mcgd_front #(
	parameter int GROUP_BYTES = mcgd_pkg::GROUP_BYTES_DEF,
	parameter int MAX_GROUPS  = mcgd_pkg::MAX_GROUPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [7:0]                        in_byte,
	input  logic                              end_of_input,
	output logic                              push,
	output logic [GROUP_BYTES-1:0][7:0]       push_data,
	output mcgd_pkg::ctl_t                    push_ctl
);
	import mcgd_pkg::*;

	localparam int FILL_W = $clog2(GROUP_BYTES + 1);
	localparam int IDX_W  = $clog2(GROUP_BYTES);
	localparam int LIMIT  = cons_limit(GROUP_BYTES, MAX_GROUPS);
	localparam logic [7:0] MARK_MIN = 8'(TOP_MARK - GROUP_BYTES);

	logic [GROUP_BYTES-1:0][7:0] store_q;
	logic [GROUP_BYTES-1:0]      nz_q;
	logic [FILL_W-1:0]           fill_q;
	logic [CONS_W-1:0]           cons_q;
	logic                        finished_q;

	logic [FILL_W-1:0]      fill_eff, pad, n;
	logic [CONS_W-1:0]      cons_eff, cons_new;
	logic [CONS_W:0]        cons_sum;
	logic [GROUP_BYTES-1:0] pad_mask;
	logic                   is_payload, low_mark, bad_pad, done_now;
	logic [7:0]             pad_full;

	// a finished key is dropped when the next byte arrives
	assign fill_eff   = finished_q ? '0 : fill_q;
	assign cons_eff   = finished_q ? '0 : cons_q;
	assign is_payload = (fill_eff < FILL_W'(GROUP_BYTES));
	assign low_mark   = (in_byte < MARK_MIN);
	assign pad_full   = 8'(TOP_MARK) - in_byte;
	assign pad        = pad_full[FILL_W-1:0];
	assign n          = FILL_W'(GROUP_BYTES) - pad;

	always_comb begin
		for (int i = 0; i < GROUP_BYTES; i++) begin
			pad_mask[i] = (FILL_W'(i) >= n);
		end
	end

	assign bad_pad  = |(nz_q & pad_mask);
	assign cons_sum = {1'b0, cons_eff} + (CONS_W + 1)'(GROUP_BYTES + 1);
	assign cons_new = (cons_sum > (CONS_W + 1)'(LIMIT)) ? CONS_W'(LIMIT) : cons_sum[CONS_W-1:0];
	// full group keeps going unless the stream ends; any padded group ends the key
	assign done_now = (pad != '0) || end_of_input;

	always_comb begin
		push_data         = store_q;
		push_ctl.cnt      = CNT_W'(1);
		push_ctl.has      = 1'b0;
		push_ctl.done     = 1'b1;
		push_ctl.err      = ERR_NONE;
		push_ctl.consumed = cons_eff;
		push              = 1'b0;
		if (accept) begin
			priority if (is_payload) begin
				push         = end_of_input;
				push_ctl.err = ERR_TRUNC;
			end else if (low_mark) begin
				push         = 1'b1;
				push_ctl.err = ERR_MARK;
			end else if (bad_pad) begin
				push         = 1'b1;
				push_ctl.err = ERR_PAD;
			end else begin
				push              = 1'b1;
				push_ctl.consumed = cons_new;
				push_ctl.has      = (n != '0);
				push_ctl.cnt      = (n != '0) ? CNT_W'(n) : CNT_W'(1);
				push_ctl.done     = done_now;
				push_ctl.err      = (pad == '0 && end_of_input) ? ERR_TRUNC : ERR_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_payload) begin
			store_q[fill_eff[IDX_W-1:0]] <= in_byte;
			nz_q[fill_eff[IDX_W-1:0]]    <= (in_byte != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			cons_q     <= '0;
			finished_q <= 1'b0;
		end else if (accept) begin
			if (is_payload) begin
				fill_q     <= fill_eff + 1'b1;
				cons_q     <= cons_eff;
				finished_q <= end_of_input;
			end else begin
				fill_q <= '0;
				if (low_mark || bad_pad) begin
					cons_q     <= cons_eff;
					finished_q <= 1'b1;
				end else begin
					cons_q     <= cons_new;
					finished_q <= done_now;
				end
			end
		end
	end

endmodule

// ===== rtl/mcgd_back.sv =====
// Back end: walks queue head words into output reg, one per cycle unless stalled.
// Depends on mcgd_pkg.
module mcgd_back #(
	parameter int GROUP_BYTES = mcgd_pkg::GROUP_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  logic [GROUP_BYTES-1:0][7:0]          head_data,
	input  mcgd_pkg::ctl_t                       head_ctl,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mcgd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tuser,
	output logic                                 m_tlast
);
	import mcgd_pkg::*;

	localparam int IDX_W = $clog2(GROUP_BYTES);

	logic [IDX_W-1:0]  k_q;
	logic              valid_q, has_q, last_q, done_q;
	logic [7:0]        byte_q;
	err_t              err_q;
	logic [CONS_W-1:0] cons_q;
	logic              emit, last_now;

	assign emit     = head_valid && (!valid_q || m_tready);
	assign last_now = (CNT_W'(k_q) == head_ctl.cnt - 1'b1);
	assign pop      = emit && last_now;

	assign m_tvalid = valid_q;
	assign m_tuser  = has_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {1'b0, cons_q, err_q, done_q, byte_q};

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= head_ctl.has ? head_data[k_q] : 8'd0;
			has_q  <= head_ctl.has;
			last_q <= last_now;
			done_q <= last_now && head_ctl.done;
			err_q  <= last_now ? head_ctl.err : ERR_NONE;
			cons_q <= head_ctl.consumed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				k_q     <= last_now ? '0 : k_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
